// File: hw/rtl/gcp_pkg.sv
package gcp_pkg;

   // Defaults for the top level parameters
   localparam int POSITION_BITS_DEFAULT = 12;
   localparam int SINE_BITS_DEFAULT     = 16;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ZERO_POSITION = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ANGLE_SLOPE   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ANGLE_OFFSET  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRAVITY_GAIN  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOWER_LIMIT   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UPPER_LIMIT   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PUSHBACK_GAIN = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PWM_LIMIT     = 3'd7;

   // Register reset values
   localparam int unsigned ZERO_POSITION_RESET = 990;
   localparam int unsigned LOWER_LIMIT_RESET   = 990;
   localparam int unsigned UPPER_LIMIT_RESET   = 1535;
   localparam logic [15:0] ANGLE_SLOPE_RESET   = 16'd4153;
   localparam logic [15:0] ANGLE_OFFSET_RESET  = 16'd3641;
   localparam logic [15:0] GRAVITY_GAIN_RESET  = 16'd6066;
   localparam logic [7:0]  PUSHBACK_GAIN_RESET = 8'd4;
   localparam logic [9:0]  PWM_LIMIT_RESET     = 10'd885;

   // Result fields
   localparam int DRIVE_BITS = 11;
   localparam int ZONE_BITS  = 2;

   localparam logic [ZONE_BITS-1:0] ZONE_NORMAL = 2'd0;
   localparam logic [ZONE_BITS-1:0] ZONE_LOWER  = 2'd1;
   localparam logic [ZONE_BITS-1:0] ZONE_UPPER  = 2'd2;

   // Quarter-wave sine polynomial coefficients, Q30
   localparam logic [30:0] SIN_A = 31'd1686629713;
   localparam logic [29:0] SIN_B = 30'd688904866;
   localparam logic [26:0] SIN_C = 27'd76016977;

endpackage

// File: hw/rtl/gcp_req_if.sv
interface gcp_req_if #(
   parameter int POSITION_BITS = gcp_pkg::POSITION_BITS_DEFAULT
);
   logic                     valid;
   logic                     ready;
   logic [POSITION_BITS-1:0] position;

   modport source (output valid, output position, input ready);
   modport sink   (input valid, input position, output ready);
endinterface

// File: hw/rtl/gcp_rsp_if.sv
interface gcp_rsp_if;
   import gcp_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DRIVE_BITS-1:0] pwm_drive;
   logic [ZONE_BITS-1:0]         zone;

   modport source (output valid, output pwm_drive, output zone, input ready);
   modport sink   (input valid, input pwm_drive, input zone, output ready);
endinterface

// File: hw/rtl/gcp_cell.sv
// One elastic pipeline cell: holds a request and passes it on when the next cell can take it.
module gcp_cell #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic             valid_ff, valid_in;
   logic [WIDTH-1:0] data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   // a held request must not vanish while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff)
      else $error("cell dropped a stalled request");

   // cell takes a request whenever it is empty
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> in_ready)
      else $error("empty cell refused a request");

   a_load: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff)
      else $error("accepted request not held");
endmodule

// File: hw/rtl/gravity_comp_pwm_with_soft_limits.sv
// Gravity compensation PWM drive with soft position limits.
//
// req_chan (sink): one joint position sample per request. rsp_chan (source):
// one signed pwm_drive and a zone code per request, in request order.
// csr_*: plain write port; csr_write_data is written to register csr_index at
// any edge with csr_write_enable high. Write only while the pipe is empty.
//
// The datapath is a row of eight identical elastic cells, one per stage:
// zone/difference, angle and pushback multiply, quarter-wave fold and z^2,
// two polynomial steps, final sine product with saturation, gain multiply,
// and the limit/sign stage whose cell is the output register.
// Throughput: one request per cycle while rsp_chan does not stall.
// A stall on rsp_chan backs up cell by cell; req_chan.ready drops only once
// every cell is full, so nothing is lost or repeated.
// Reset (synchronous) empties the pipe and loads the register defaults.
module gravity_comp_pwm_with_soft_limits #(
   parameter int POSITION_BITS = gcp_pkg::POSITION_BITS_DEFAULT,
   parameter int SINE_BITS     = gcp_pkg::SINE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gcp_req_if.sink                              req_chan,
   gcp_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [gcp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gcp_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import gcp_pkg::*;

   localparam int PB     = POSITION_BITS;
   localparam int PBW    = POSITION_BITS + 8;   // pushback product
   localparam int PW     = POSITION_BITS + 18;  // angle product
   localparam int SSHIFT = 31 - SINE_BITS;
   localparam int GW     = SINE_BITS + 15;      // gain product
   localparam logic [SINE_BITS-2:0] SMAX = {(SINE_BITS-1){1'b1}};

   // ---------------- configuration registers ----------------
   logic [PB-1:0] zero_position_ff, lower_limit_ff, upper_limit_ff;
   logic [15:0]   angle_slope_ff, angle_offset_ff, gravity_gain_ff;
   logic [7:0]    pushback_gain_ff;
   logic [9:0]    pwm_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_position_ff <= PB'(ZERO_POSITION_RESET);
         angle_slope_ff   <= ANGLE_SLOPE_RESET;
         angle_offset_ff  <= ANGLE_OFFSET_RESET;
         gravity_gain_ff  <= GRAVITY_GAIN_RESET;
         lower_limit_ff   <= PB'(LOWER_LIMIT_RESET);
         upper_limit_ff   <= PB'(UPPER_LIMIT_RESET);
         pushback_gain_ff <= PUSHBACK_GAIN_RESET;
         pwm_limit_ff     <= PWM_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ZERO_POSITION: zero_position_ff <= csr_write_data[PB-1:0];
            REG_ANGLE_SLOPE:   angle_slope_ff   <= csr_write_data;
            REG_ANGLE_OFFSET:  angle_offset_ff  <= csr_write_data;
            REG_GRAVITY_GAIN:  gravity_gain_ff  <= csr_write_data;
            REG_LOWER_LIMIT:   lower_limit_ff   <= csr_write_data[PB-1:0];
            REG_UPPER_LIMIT:   upper_limit_ff   <= csr_write_data[PB-1:0];
            REG_PUSHBACK_GAIN: pushback_gain_ff <= csr_write_data[7:0];
            REG_PWM_LIMIT:     pwm_limit_ff     <= csr_write_data[9:0];
            default: ;
         endcase
      end
   end

   // ---------------- per-stage payloads ----------------
   typedef struct packed {
      logic signed [PB:0]   diff;
      logic [ZONE_BITS-1:0] zone;
      logic [PB-1:0]        overshoot;
   } s0_type;

   typedef struct packed {
      logic [15:0]          phase;
      logic [ZONE_BITS-1:0] zone;
      logic [PBW-1:0]       pb;
   } s1_type;

   typedef struct packed {
      logic [14:0]          z;
      logic [14:0]          z2;
      logic                 neg;
      logic [ZONE_BITS-1:0] zone;
      logic [PBW-1:0]       pb;
   } s2_type;

   typedef struct packed {
      logic [29:0]          t1;
      logic [14:0]          z;
      logic [14:0]          z2;
      logic                 neg;
      logic [ZONE_BITS-1:0] zone;
      logic [PBW-1:0]       pb;
   } s3_type;

   typedef struct packed {
      logic [30:0]          t2;
      logic [14:0]          z;
      logic                 neg;
      logic [ZONE_BITS-1:0] zone;
      logic [PBW-1:0]       pb;
   } s4_type;

   typedef struct packed {
      logic [SINE_BITS-2:0] smag;
      logic                 neg;
      logic [ZONE_BITS-1:0] zone;
      logic [PBW-1:0]       pb;
   } s5_type;

   typedef struct packed {
      logic [7:0]           m;
      logic                 neg;
      logic [ZONE_BITS-1:0] zone;
      logic [PBW-1:0]       pb;
   } s6_type;

   typedef struct packed {
      logic signed [DRIVE_BITS-1:0] drive;
      logic [ZONE_BITS-1:0]         zone;
   } s7_type;

   s0_type s0_in, s0_q;
   s1_type s1_in, s1_q;
   s2_type s2_in, s2_q;
   s3_type s3_in, s3_q;
   s4_type s4_in, s4_q;
   s5_type s5_in, s5_q;
   s6_type s6_in, s6_q;
   s7_type s7_in, s7_q;

   logic [7:0] vld, rdy;

   // ---------------- stage 0: zone decision, offsets ----------------
   logic at_lower, at_upper;

   always_comb begin
      at_lower = (req_chan.position <= lower_limit_ff);
      at_upper = (req_chan.position >= upper_limit_ff);
      s0_in.diff = $signed({1'b0, req_chan.position}) - $signed({1'b0, zero_position_ff});
      if (at_lower) begin
         // lower test first: it wins when the limits overlap
         s0_in.zone      = ZONE_LOWER;
         s0_in.overshoot = lower_limit_ff - req_chan.position;
      end else if (at_upper) begin
         s0_in.zone      = ZONE_UPPER;
         s0_in.overshoot = req_chan.position - upper_limit_ff;
      end else begin
         s0_in.zone      = ZONE_NORMAL;
         s0_in.overshoot = '0;
      end
   end

   // ---------------- stage 1: binary angle and pushback product ----------------
   logic signed [PW-1:0] angle_prod;

   always_comb begin
      angle_prod  = s0_q.diff * $signed({1'b0, angle_slope_ff});
      // bits 8..23 are floor(prod/256) mod 2^16
      s1_in.phase = angle_prod[23:8] + angle_offset_ff;
      s1_in.zone  = s0_q.zone;
      s1_in.pb    = {8'd0, s0_q.overshoot} * {{PB{1'b0}}, pushback_gain_ff};
   end

   // ---------------- stage 2: quarter-wave fold, z^2 ----------------
   logic [14:0] fold_z;
   logic [29:0] zz;

   always_comb begin
      fold_z     = s1_q.phase[14] ? (15'd16384 - {1'b0, s1_q.phase[13:0]})
                                  : {1'b0, s1_q.phase[13:0]};
      zz         = {15'd0, fold_z} * {15'd0, fold_z};
      s2_in.z    = fold_z;
      s2_in.z2   = zz[28:14];
      s2_in.neg  = s1_q.phase[15];
      s2_in.zone = s1_q.zone;
      s2_in.pb   = s1_q.pb;
   end

   // ---------------- stage 3: t1 = B - C*z2 ----------------
   logic [41:0] cz2;

   always_comb begin
      cz2        = {15'd0, SIN_C} * {27'd0, s2_q.z2};
      s3_in.t1   = SIN_B - {2'b00, cz2[41:14]};
      s3_in.z    = s2_q.z;
      s3_in.z2   = s2_q.z2;
      s3_in.neg  = s2_q.neg;
      s3_in.zone = s2_q.zone;
      s3_in.pb   = s2_q.pb;
   end

   // ---------------- stage 4: t2 = A - t1*z2 ----------------
   logic [44:0] tz2;

   always_comb begin
      tz2        = {15'd0, s3_q.t1} * {30'd0, s3_q.z2};
      s4_in.t2   = SIN_A - tz2[44:14];
      s4_in.z    = s3_q.z;
      s4_in.neg  = s3_q.neg;
      s4_in.zone = s3_q.zone;
      s4_in.pb   = s3_q.pb;
   end

   // ---------------- stage 5: sine = t2*z, scaled and saturated ----------------
   logic [45:0] tz;
   logic [31:0] sine_full;

   always_comb begin
      tz        = {15'd0, s4_q.t2} * {31'd0, s4_q.z};
      sine_full = tz[45:14] >> SSHIFT;
      if (sine_full > 32'(SMAX)) begin
         s5_in.smag = SMAX;
      end else begin
         s5_in.smag = sine_full[SINE_BITS-2:0];
      end
      s5_in.neg  = s4_q.neg;
      s5_in.zone = s4_q.zone;
      s5_in.pb   = s4_q.pb;
   end

   // ---------------- stage 6: gain * |sine| ----------------
   logic [GW-1:0] gain_prod;

   always_comb begin
      gain_prod  = {{(SINE_BITS-1){1'b0}}, gravity_gain_ff} * {16'd0, s5_q.smag};
      // at most 255 after the Q8 and sine scaling
      s6_in.m    = gain_prod[GW-1:SINE_BITS+7];
      s6_in.neg  = s5_q.neg;
      s6_in.zone = s5_q.zone;
      s6_in.pb   = s5_q.pb;
   end

   // ---------------- stage 7: limit, sign, output register ----------------
   logic [9:0] mag_norm, mag_push, mag;
   logic       negate;

   always_comb begin
      mag_norm = ({2'b00, s6_q.m} > pwm_limit_ff) ? pwm_limit_ff : {2'b00, s6_q.m};
      mag_push = (s6_q.pb > PBW'(pwm_limit_ff)) ? pwm_limit_ff : s6_q.pb[9:0];
      mag      = (s6_q.zone == ZONE_NORMAL) ? mag_norm : mag_push;
      // drive opposes gravity: negative when the sine is positive
      negate   = (s6_q.zone == ZONE_UPPER) || ((s6_q.zone == ZONE_NORMAL) && !s6_q.neg);
      s7_in.drive = negate ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      s7_in.zone  = s6_q.zone;
   end

   // ---------------- cell row ----------------
   gcp_cell #(.WIDTH($bits(s0_type))) u_cell0 (
      .clock, .reset,
      .in_valid(req_chan.valid), .in_ready(rdy[0]), .in_data(s0_in),
      .out_valid(vld[0]), .out_ready(rdy[1]), .out_data(s0_q));

   gcp_cell #(.WIDTH($bits(s1_type))) u_cell1 (
      .clock, .reset,
      .in_valid(vld[0]), .in_ready(rdy[1]), .in_data(s1_in),
      .out_valid(vld[1]), .out_ready(rdy[2]), .out_data(s1_q));

   gcp_cell #(.WIDTH($bits(s2_type))) u_cell2 (
      .clock, .reset,
      .in_valid(vld[1]), .in_ready(rdy[2]), .in_data(s2_in),
      .out_valid(vld[2]), .out_ready(rdy[3]), .out_data(s2_q));

   gcp_cell #(.WIDTH($bits(s3_type))) u_cell3 (
      .clock, .reset,
      .in_valid(vld[2]), .in_ready(rdy[3]), .in_data(s3_in),
      .out_valid(vld[3]), .out_ready(rdy[4]), .out_data(s3_q));

   gcp_cell #(.WIDTH($bits(s4_type))) u_cell4 (
      .clock, .reset,
      .in_valid(vld[3]), .in_ready(rdy[4]), .in_data(s4_in),
      .out_valid(vld[4]), .out_ready(rdy[5]), .out_data(s4_q));

   gcp_cell #(.WIDTH($bits(s5_type))) u_cell5 (
      .clock, .reset,
      .in_valid(vld[4]), .in_ready(rdy[5]), .in_data(s5_in),
      .out_valid(vld[5]), .out_ready(rdy[6]), .out_data(s5_q));

   gcp_cell #(.WIDTH($bits(s6_type))) u_cell6 (
      .clock, .reset,
      .in_valid(vld[5]), .in_ready(rdy[6]), .in_data(s6_in),
      .out_valid(vld[6]), .out_ready(rdy[7]), .out_data(s6_q));

   gcp_cell #(.WIDTH($bits(s7_type))) u_cell7 (
      .clock, .reset,
      .in_valid(vld[6]), .in_ready(rdy[7]), .in_data(s7_in),
      .out_valid(vld[7]), .out_ready(rsp_chan.ready), .out_data(s7_q));

   assign req_chan.ready     = rdy[0];
   assign rsp_chan.valid     = vld[7];
   assign rsp_chan.pwm_drive = s7_q.drive;
   assign rsp_chan.zone      = s7_q.zone;

   // ---------------- checks ----------------
   a_lower_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.zone == ZONE_LOWER) |-> !rsp_chan.pwm_drive[DRIVE_BITS-1])
      else $error("lower limit pushback went negative");

   a_upper_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.zone == ZONE_UPPER)
      |-> rsp_chan.pwm_drive[DRIVE_BITS-1] || (rsp_chan.pwm_drive == '0))
      else $error("upper limit pushback went positive");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.zone == ZONE_NORMAL)
      |-> (rsp_chan.pwm_drive <= 11'sd255) && (rsp_chan.pwm_drive >= -11'sd255))
      else $error("compensation drive out of range");

   a_zone_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.zone != 2'd3))
      else $error("undefined zone code");
endmodule

// File: tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gcp_pkg::*;

   // Block configuration as instantiated (package defaults)
   localparam int POS_W   = POSITION_BITS_DEFAULT;
   localparam int SINE_W  = SINE_BITS_DEFAULT;
   localparam int POS_MAX = (1 << POS_W) - 1;

   // Drain wait used after each phase and before the final report
   localparam int PIPE_LATENCY = 7;

   // Generous ceiling for the watchdog
   localparam int CYCLE_LIMIT = 200_000;

   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 170;

   // Quarter-wave sine polynomial, Q30
   localparam longint unsigned Q30_A    = 64'd1686629713;
   localparam longint unsigned Q30_B    = 64'd688904866;
   localparam longint unsigned Q30_C    = 64'd76016977;
   localparam longint unsigned SINE_MAX = (64'd1 << (SINE_W - 1)) - 64'd1;

   // One predicted result, with the position that caused it for reporting
   typedef struct {
      logic [POS_W-1:0]             position;
      logic signed [DRIVE_BITS-1:0] pwm_drive;
      logic [ZONE_BITS-1:0]         zone;
   } drive_expect_type;

   bit   clock;
   logic reset;

   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   gcp_req_if #(.POSITION_BITS(POS_W)) req_bus ();
   gcp_rsp_if                          rsp_bus ();

   gravity_comp_pwm_with_soft_limits #(
      .POSITION_BITS (POS_W),
      .SINE_BITS     (SINE_W)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the register file, kept in step with every write
   logic [POS_W-1:0] cfg_zero;
   logic [15:0]      cfg_slope;
   logic [15:0]      cfg_offset;
   logic [15:0]      cfg_gain;
   logic [POS_W-1:0] cfg_lower;
   logic [POS_W-1:0] cfg_upper;
   logic [7:0]       cfg_pushback;
   logic [9:0]       cfg_pwm_limit;

   logic [POS_W-1:0] pending_positions[$];   // waiting to be offered
   drive_expect_type expected_drives[$];     // accepted, result not yet seen

   bit req_taken;     // request accepted at the last rising edge
   bit hold_sender;   // sender held off while the pipe drains
   int sender_idle_pct;
   int receiver_stall_pct;

   int cycle_count;
   int queued_total;
   int accepted_total;
   int results_checked;
   int mismatch_count;
   int settings_used;
   int zone_seen[3];

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // -----------------------------------------------------------------------
   // Predictor: zone select, binary angle, polynomial sine, gain and clamp
   // -----------------------------------------------------------------------
   function automatic drive_expect_type compute_drive(input logic [POS_W-1:0] position);
      drive_expect_type res;
      longint signed   angle_prod;
      logic [15:0]     phase;
      longint unsigned z, z2, poly, sine, mag;
      res.position = position;
      if (position <= cfg_lower) begin
         // lower limit is tested first, so it wins when the limits overlap
         mag = (64'(cfg_lower) - 64'(position)) * 64'(cfg_pushback);
         if (mag > 64'(cfg_pwm_limit)) mag = 64'(cfg_pwm_limit);
         res.pwm_drive = DRIVE_BITS'(mag);
         res.zone      = ZONE_LOWER;
      end else if (position >= cfg_upper) begin
         mag = (64'(position) - 64'(cfg_upper)) * 64'(cfg_pushback);
         if (mag > 64'(cfg_pwm_limit)) mag = 64'(cfg_pwm_limit);
         res.pwm_drive = DRIVE_BITS'(-mag);
         res.zone      = ZONE_UPPER;
      end else begin
         // signed product; bits 23:8 are floor(prod/256) mod 2^16
         angle_prod = (longint'(position) - longint'(cfg_zero)) * longint'(cfg_slope);
         phase      = angle_prod[23:8] + cfg_offset;
         // fold onto the first quarter wave
         z    = phase[14] ? 64'd16384 - 64'(phase[13:0]) : 64'(phase[13:0]);
         z2   = (z * z) >> 14;
         poly = Q30_B - ((Q30_C * z2) >> 14);
         poly = Q30_A - ((poly * z2) >> 14);
         sine = ((poly * z) >> 14) >> (31 - SINE_W);
         if (sine > SINE_MAX) sine = SINE_MAX;
         mag = (64'(cfg_gain) * sine) >> (SINE_W + 7);
         if (mag > 64'(cfg_pwm_limit)) mag = 64'(cfg_pwm_limit);
         // drive opposes the sine: negative half-wave gives positive drive
         res.pwm_drive = phase[15] ? DRIVE_BITS'(mag) : DRIVE_BITS'(-mag);
         res.zone      = ZONE_NORMAL;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t ns mismatch: %s", $time, msg);
   endtask

   // -----------------------------------------------------------------------
   // Request driver: changes on the falling edge, holds until accepted
   // -----------------------------------------------------------------------
   always @(negedge clock) begin : request_driver
      if (reset) begin
         req_bus.valid    <= 1'b0;
         req_bus.position <= '0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_positions.size() != 0 && !hold_sender &&
             $urandom_range(99) >= sender_idle_pct) begin
            req_bus.valid    <= 1'b1;
            req_bus.position <= pending_positions.pop_front();
         end else begin
            req_bus.valid    <= 1'b0;
            req_bus.position <= POS_W'($urandom);   // junk while idle
         end
      end
   end

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin : result_ready
      rsp_bus.ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // -----------------------------------------------------------------------
   // Monitor: on each rising edge log accepted requests and check results
   // in order against the oldest prediction
   // -----------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      drive_expect_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            req_taken = 1'b1;
            expected_drives.push_back(compute_drive(req_bus.position));
            accepted_total++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_drives.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: drive %0d zone %0d",
                                         rsp_bus.pwm_drive, rsp_bus.zone));
            end else begin
               want = expected_drives.pop_front();
               results_checked++;
               if (want.zone <= ZONE_UPPER) zone_seen[want.zone]++;
               if (rsp_bus.pwm_drive !== want.pwm_drive)
                  report_mismatch($sformatf("position %0d: pwm_drive %0d, wanted %0d",
                                            want.position, rsp_bus.pwm_drive,
                                            want.pwm_drive));
               if (rsp_bus.zone !== want.zone)
                  report_mismatch($sformatf("position %0d: zone %0d, wanted %0d",
                                            want.position, rsp_bus.zone, want.zone));
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // Register writes: called on a falling edge with the pipe empty. The
   // shadow copy applies the same truncation as the register widths.
   // -----------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0]  data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         REG_ZERO_POSITION: cfg_zero      = data[POS_W-1:0];
         REG_ANGLE_SLOPE:   cfg_slope     = data[15:0];
         REG_ANGLE_OFFSET:  cfg_offset    = data[15:0];
         REG_GRAVITY_GAIN:  cfg_gain      = data[15:0];
         REG_LOWER_LIMIT:   cfg_lower     = data[POS_W-1:0];
         REG_UPPER_LIMIT:   cfg_upper     = data[POS_W-1:0];
         REG_PUSHBACK_GAIN: cfg_pushback  = data[7:0];
         REG_PWM_LIMIT:     cfg_pwm_limit = data[9:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] zero, input logic [15:0] slope,
                                 input logic [15:0] offset, input logic [15:0] gain,
                                 input logic [15:0] lower, input logic [15:0] upper,
                                 input logic [15:0] pushback, input logic [15:0] pwm_lim);
      write_reg(REG_ZERO_POSITION, zero);
      write_reg(REG_ANGLE_SLOPE,   slope);
      write_reg(REG_ANGLE_OFFSET,  offset);
      write_reg(REG_GRAVITY_GAIN,  gain);
      write_reg(REG_LOWER_LIMIT,   lower);
      write_reg(REG_UPPER_LIMIT,   upper);
      write_reg(REG_PUSHBACK_GAIN, pushback);
      write_reg(REG_PWM_LIMIT,     pwm_lim);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Value in the low bits, random junk above so every data bit toggles
   function automatic logic [15:0] with_noise(input int unsigned value, input int bits);
      return 16'(($urandom << bits) | value);
   endfunction

   task automatic random_settings();
      int          lo, hi, pwm_lim;
      logic [15:0] slope;
      case ($urandom_range(3))
         0: begin                       // wide normal zone
            lo = $urandom_range(300);
            hi = $urandom_range(POS_MAX, 3800);
         end
         1: begin
            lo = $urandom_range(2000);
            hi = $urandom_range(POS_MAX, 2000);
         end
         2: begin                       // anything, overlap included
            lo = $urandom_range(POS_MAX);
            hi = $urandom_range(POS_MAX);
         end
         default: begin                 // narrow window
            lo = $urandom_range(3900);
            hi = lo + $urandom_range(195, 1);
         end
      endcase
      case ($urandom_range(3))
         0:       pwm_lim = 885;
         1:       pwm_lim = 1023;
         2:       pwm_lim = $urandom_range(64);
         default: pwm_lim = $urandom_range(1023);
      endcase
      // slow slopes keep the angle near one spot, fast ones wrap often
      slope = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1024));
      apply_settings(with_noise($urandom_range(POS_MAX), POS_W), slope,
                     16'($urandom), 16'($urandom),
                     with_noise(lo, POS_W), with_noise(hi, POS_W),
                     with_noise($urandom_range(255), 8), with_noise(pwm_lim, 10));
   endtask

   // Mostly inside the normal zone, some hugging a limit, rest anywhere
   function automatic logic [POS_W-1:0] pick_position();
      int p;
      int sel;
      sel = $urandom_range(99);
      if (sel < 60 && cfg_lower < cfg_upper) begin
         p = $urandom_range(cfg_upper, cfg_lower);
      end else if (sel < 75) begin
         p = ($urandom_range(1) ? int'(cfg_lower) : int'(cfg_upper)) +
             int'($urandom_range(6)) - 3;
         if (p < 0) p = 0;
         if (p > POS_MAX) p = POS_MAX;
      end else begin
         p = $urandom_range(POS_MAX);
      end
      return POS_W'(p);
   endfunction

   task automatic queue_position(input int unsigned position);
      pending_positions.push_back(POS_W'(position));
      queued_total++;
   endtask

   // Let the queued requests run under the given idling, optionally holding
   // the sender half way until every outstanding result is back.
   task automatic run_phase(input int sender_idle, input int receiver_stall,
                            input bit pause_midway);
      int half;
      half               = pending_positions.size() / 2;
      sender_idle_pct    = sender_idle;
      receiver_stall_pct = receiver_stall;
      if (pause_midway) begin
         while (pending_positions.size() > half) @(negedge clock);
         hold_sender = 1'b1;
         @(negedge clock);
         while (req_bus.valid || expected_drives.size() != 0) @(negedge clock);
         hold_sender = 1'b0;
      end
      while (accepted_total != queued_total || expected_drives.size() != 0)
         @(negedge clock);
      repeat (PIPE_LATENCY) @(negedge clock);
   endtask

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[gravity_comp_pwm_with_soft_limits] ERROR");
      $finish;
   end

   // -----------------------------------------------------------------------
   // Stimulus sequence
   // -----------------------------------------------------------------------
   initial begin : stimulus
      int send_pct;
      int stall_pct;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = REG_ZERO_POSITION;
      csr_write_data   = '0;

      cfg_zero      = POS_W'(ZERO_POSITION_RESET);
      cfg_slope     = ANGLE_SLOPE_RESET;
      cfg_offset    = ANGLE_OFFSET_RESET;
      cfg_gain      = GRAVITY_GAIN_RESET;
      cfg_lower     = POS_W'(LOWER_LIMIT_RESET);
      cfg_upper     = POS_W'(UPPER_LIMIT_RESET);
      cfg_pushback  = PUSHBACK_GAIN_RESET;
      cfg_pwm_limit = PWM_LIMIT_RESET;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: position extremes and both sides of each limit
      queue_position(0);
      queue_position(POS_MAX);
      queue_position(989);
      queue_position(990);
      queue_position(991);
      queue_position(1534);
      queue_position(1535);
      queue_position(1536);
      queue_position(1262);
      run_phase(0, 0, 1'b0);

      // All-ones writes but lower limit 0: upper bits dropped, largest gains, pwm_limit 1023,
      // zero point at the top so the angle difference goes negative
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_position(0);
      queue_position(1);
      queue_position(2048);
      queue_position(4094);
      queue_position(POS_MAX);
      run_phase(0, 0, 1'b0);

      // Overlapping limits with a zero pwm_limit: lower test must win
      apply_settings(0, 300, 0, 6066, 3000, 1000, 255, 0);
      queue_position(2999);
      queue_position(3000);
      queue_position(3001);
      run_phase(0, 0, 1'b0);

      // Zero gravity and pushback gains, zones still reported
      apply_settings(0, 256, 0, 0, 100, 4000, 0, 885);
      queue_position(50);
      queue_position(2000);
      queue_position(4050);
      run_phase(0, 0, 1'b0);

      // Angle pinned at a quarter turn: sine saturates, full gain
      apply_settings(0, 0, 16384, 16'hFFFF, 0, 16'(POS_MAX), 255, 1023);
      queue_position(1000);
      queue_position(0);
      queue_position(POS_MAX);
      run_phase(0, 0, 1'b0);

      // Random settings, cycling through the idling patterns; the
      // stall-only phases also hold the sender off part way through
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         case (k % 4)
            0:       begin send_pct = 0;  stall_pct = 0;  end
            1:       begin send_pct = 56; stall_pct = 0;  end
            2:       begin send_pct = 0;  stall_pct = 56; end
            default: begin send_pct = 24; stall_pct = 24; end
         endcase
         random_settings();
         repeat (ITEMS_PER_PHASE) queue_position(pick_position());
         run_phase(send_pct, stall_pct, (k % 4) == 2);
      end

      repeat (2 * PIPE_LATENCY) @(negedge clock);

      $display("Covered %0d requests, %0d results checked, over %0d register settings.",
               accepted_total, results_checked, settings_used + 1);
      $display("Zones seen: normal %0d, lower limit %0d, upper limit %0d; %0d mismatches.",
               zone_seen[0], zone_seen[1], zone_seen[2], mismatch_count);
      if (mismatch_count == 0)
         $display("[gravity_comp_pwm_with_soft_limits] OK");
      else
         $display("[gravity_comp_pwm_with_soft_limits] ERROR");
      $finish;
   end

endmodule

// File: gravity_comp_pwm_with_soft_limits.f
hw/rtl/gcp_pkg.sv
hw/rtl/gcp_req_if.sv
hw/rtl/gcp_rsp_if.sv
hw/rtl/gcp_cell.sv
hw/rtl/gravity_comp_pwm_with_soft_limits.sv
tb/sv/tb_top.sv
